FILE: design/rle_spr_pkg.sv
// Package with the phase type, status codes and constants of the RLE sprite decoder.
`default_nettype none

package rle_spr_pkg;

	typedef enum logic [2:0] {
		PH_WIDTH   = 3'd0,
		PH_HEIGHT  = 3'd1,
		PH_ROWLEN  = 3'd2,
		PH_SEGCNT  = 3'd3,
		PH_SKIP    = 3'd4,
		PH_COUNT   = 3'd5,
		PH_PIXEL   = 3'd6,
		PH_STOPPED = 3'd7
	} phase_t;

	localparam logic [1:0] ST_PIXEL   = 2'd0;
	localparam logic [1:0] ST_DROPPED = 2'd1;
	localparam logic [1:0] ST_ABORT   = 2'd2;
	localparam logic [1:0] ST_DONE    = 2'd3;

	localparam logic [16:0] COL_MAX     = 17'h1FFFF;
	localparam logic [7:0]  ALPHA_FULL  = 8'hFF;

endpackage

`default_nettype wire

FILE: design/rle_spr_words_if.sv
// Interface of the input channel that carries sprite stream words.
`default_nettype none

interface rle_spr_words_if;
	logic        valid;
	logic        ready;
	logic        restart;
	logic [15:0] word;

	modport source (output valid, output restart, output word, input ready);
	modport sink (input valid, input restart, input word, output ready);
endinterface

`default_nettype wire

FILE: design/rle_spr_pixels_if.sv
// Interface of the output channel that carries decoded pixels and sprite status.
`default_nettype none

interface rle_spr_pixels_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [15:0] column;
	logic [15:0] row;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [7:0]  alpha;

	modport source (output valid, output status, output column, output row, output red,
		output green, output blue, output alpha, input ready);
	modport sink (input valid, input status, input column, input row, input red,
		input green, input blue, input alpha, output ready);
endinterface

`default_nettype wire

FILE: design/rle_sprite_rgb565_decoder.sv
// Top level of the RLE transparent sprite decoder with RGB565 to RGBA8888 expansion.
// A result is registered on the transaction of the word that causes it.
// Throughput: one stream word per cycle while no result is stalled, set by the phase update.
// A stalled result holds in the output register and stops new words only then.
// Reset clears the decoder state to wait for a width word and empties the output register.
`default_nettype none

module rle_sprite_rgb565_decoder
	import rle_spr_pkg::*;
(
	input  wire              clk,
	input  wire              arst_n,
	rle_spr_words_if.sink    words,
	rle_spr_pixels_if.source pixels
);

	phase_t      ph_q, ph_d;
	logic [15:0] width_q, width_d;
	logic [15:0] height_q, height_d;
	logic [15:0] row_q, row_d;
	logic [15:0] rwl_q, rwl_d;
	logic [15:0] seg_q, seg_d;
	logic [15:0] clr_q, clr_d;
	logic [16:0] col_q, col_d;

	logic        res_valid_q;
	logic [1:0]  res_status_q;
	logic [15:0] res_column_q;
	logic [15:0] res_row_q;
	logic [7:0]  res_red_q;
	logic [7:0]  res_green_q;
	logic [7:0]  res_blue_q;
	logic [7:0]  res_alpha_q;

	logic        accept;
	logic        res_emit;
	logic [1:0]  res_status;
	logic [15:0] res_column;
	logic [15:0] res_row;
	logic [7:0]  res_red;
	logic [7:0]  res_green;
	logic [7:0]  res_blue;
	logic [7:0]  res_alpha;
	logic [17:0] skip_sum;
	logic [15:0] rwl_dec;
	logic [15:0] row_inc;
	logic        row_end;
	logic        sent_pixel;
	logic [4:0]  r5;
	logic [5:0]  g6;
	logic [4:0]  b5;

	assign words.ready = !res_valid_q || pixels.ready;
	assign accept      = words.valid && words.ready;

	always_comb begin
		ph_d       = ph_q;
		width_d    = width_q;
		height_d   = height_q;
		row_d      = row_q;
		rwl_d      = rwl_q;
		seg_d      = seg_q;
		clr_d      = clr_q;
		col_d      = col_q;
		res_emit   = 1'b0;
		res_status = ST_PIXEL;
		res_column = 16'd0;
		res_row    = 16'd0;
		res_red    = 8'd0;
		res_green  = 8'd0;
		res_blue   = 8'd0;
		res_alpha  = 8'd0;
		row_end    = 1'b0;
		sent_pixel = 1'b0;
		r5         = words.word[15:11];
		g6         = words.word[10:5];
		b5         = words.word[4:0];
		skip_sum   = {1'b0, col_q} + {2'b00, words.word};
		rwl_dec    = rwl_q - 16'd1;
		row_inc    = row_q + 16'd1;

		if (ph_q == PH_STOPPED || words.restart || ph_q == PH_WIDTH) begin
			if (ph_q == PH_STOPPED && row_q >= height_q) begin
				res_emit   = 1'b1;
				res_status = ST_DONE;
				res_row    = height_q;
			end
			if (ph_q != PH_STOPPED || row_q >= height_q || words.restart) begin
				width_d  = words.word;
				height_d = 16'd0;
				row_d    = 16'd0;
				rwl_d    = 16'd0;
				seg_d    = 16'd0;
				clr_d    = 16'd0;
				col_d    = 17'd0;
				ph_d     = PH_HEIGHT;
			end
		end else if (ph_q == PH_HEIGHT) begin
			height_d = words.word;
			row_d    = 16'd0;
			if (width_q == 16'd0 || words.word == 16'd0) begin
				res_emit   = 1'b1;
				res_status = ST_DONE;
				ph_d       = PH_WIDTH;
			end else begin
				ph_d = PH_ROWLEN;
			end
		end else begin
			if (ph_q == PH_ROWLEN) begin
				rwl_d   = words.word;
				col_d   = 17'd0;
				seg_d   = 16'd0;
				clr_d   = 16'd0;
				ph_d    = PH_SEGCNT;
				row_end = (words.word == 16'd0);
			end else begin
				rwl_d   = rwl_dec;
				row_end = (rwl_dec == 16'd0);
				unique case (ph_q)
					PH_SEGCNT: begin
						if (words.word > width_q) begin
							res_emit   = 1'b1;
							res_status = ST_ABORT;
							res_row    = row_q;
							ph_d       = PH_STOPPED;
							row_end    = 1'b0;
						end else begin
							seg_d = words.word;
							ph_d  = PH_SKIP;
						end
					end
					PH_SKIP: begin
						if (seg_q != 16'd0) begin
							col_d = skip_sum[17] ? COL_MAX : skip_sum[16:0];
							ph_d  = PH_COUNT;
						end
					end
					PH_COUNT: begin
						clr_d = words.word;
						seg_d = seg_q - 16'd1;
						ph_d  = (words.word != 16'd0) ? PH_PIXEL : PH_SKIP;
					end
					PH_PIXEL: begin
						res_emit   = 1'b1;
						sent_pixel = 1'b1;
						res_status = (col_q >= {1'b0, width_q}) ? ST_DROPPED : ST_PIXEL;
						res_column = col_q[16] ? 16'hFFFF : col_q[15:0];
						res_row    = row_q;
						res_red    = {r5, r5[4:2]};
						res_green  = {g6, g6[5:4]};
						res_blue   = {b5, b5[4:2]};
						res_alpha  = ALPHA_FULL;
						col_d      = (col_q != COL_MAX) ? col_q + 17'd1 : col_q;
						clr_d      = clr_q - 16'd1;
						if (clr_q == 16'd1) begin
							ph_d = PH_SKIP;
						end
					end
					default: begin
					end
				endcase
			end
			if (row_end) begin
				row_d = row_inc;
				col_d = 17'd0;
				seg_d = 16'd0;
				clr_d = 16'd0;
				if (row_inc >= height_q) begin
					if (sent_pixel) begin
						ph_d = PH_STOPPED;
					end else begin
						res_emit   = 1'b1;
						res_status = ST_DONE;
						res_column = 16'd0;
						res_row    = row_inc;
						res_red    = 8'd0;
						res_green  = 8'd0;
						res_blue   = 8'd0;
						res_alpha  = 8'd0;
						ph_d       = PH_WIDTH;
					end
				end else begin
					ph_d = PH_ROWLEN;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q     <= PH_WIDTH;
			width_q  <= 16'd0;
			height_q <= 16'd0;
			row_q    <= 16'd0;
			rwl_q    <= 16'd0;
			seg_q    <= 16'd0;
			clr_q    <= 16'd0;
			col_q    <= 17'd0;
		end else if (accept) begin
			ph_q     <= ph_d;
			width_q  <= width_d;
			height_q <= height_d;
			row_q    <= row_d;
			rwl_q    <= rwl_d;
			seg_q    <= seg_d;
			clr_q    <= clr_d;
			col_q    <= col_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (accept) begin
			res_valid_q <= res_emit;
		end else if (pixels.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && res_emit) begin
			res_status_q <= res_status;
			res_column_q <= res_column;
			res_row_q    <= res_row;
			res_red_q    <= res_red;
			res_green_q  <= res_green;
			res_blue_q   <= res_blue;
			res_alpha_q  <= res_alpha;
		end
	end

	assign pixels.valid  = res_valid_q;
	assign pixels.status = res_status_q;
	assign pixels.column = res_column_q;
	assign pixels.row    = res_row_q;
	assign pixels.red    = res_red_q;
	assign pixels.green  = res_green_q;
	assign pixels.blue   = res_blue_q;
	assign pixels.alpha  = res_alpha_q;

endmodule

`default_nettype wire

FILE: design/rle_spr_checker.sv
// Port-level checker of the RLE sprite decoder and its bind to the top level.
`default_nettype none

module rle_spr_checker
	import rle_spr_pkg::*;
(
	input wire        clk,
	input wire        arst_n,
	input wire        in_valid,
	input wire        in_ready,
	input wire        out_valid,
	input wire        out_ready,
	input wire [1:0]  status,
	input wire [15:0] column,
	input wire [7:0]  red,
	input wire [7:0]  green,
	input wire [7:0]  blue,
	input wire [7:0]  alpha
);

	// A stalled result stays valid and keeps its status and column unchanged.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(status) && $stable(column))
		else $error("stalled result changed");

	// A full output register that is not drained must block new words.
	a_block: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |-> !in_ready)
		else $error("word taken while result stalled");

	// A new result only follows a word transaction.
	a_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready))
		else $error("result without input transaction");

	// Pixels carry full alpha and widened channels; status results carry zeros.
	a_fields: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((status == ST_PIXEL || status == ST_DROPPED)
			? (alpha == ALPHA_FULL && red[2:0] == red[7:5] && green[1:0] == green[7:6]
				&& blue[2:0] == blue[7:5])
			: (alpha == 8'd0 && red == 8'd0 && green == 8'd0 && blue == 8'd0
				&& column == 16'd0)))
		else $error("result fields inconsistent with status");

endmodule

bind rle_sprite_rgb565_decoder rle_spr_checker u_rle_spr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (words.valid),
	.in_ready  (words.ready),
	.out_valid (pixels.valid),
	.out_ready (pixels.ready),
	.status    (pixels.status),
	.column    (pixels.column),
	.red       (pixels.red),
	.green     (pixels.green),
	.blue      (pixels.blue),
	.alpha     (pixels.alpha)
);

`default_nettype wire
